// File: hw/rtl/button_debounce_press_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce / press classifier checks
// Clocked on clock; the first form is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// property checked outside reset
`define BDPC_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that must also hold across reset
`define BDPC_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared constants and types of the button debounce / press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int unsigned TIME_WIDTH_DEF = 32;
   localparam int unsigned CFG_W          = 20;
   localparam int unsigned CSR_IDX_W      = 2;
   localparam int unsigned KIND_W         = 2;
   localparam int unsigned TSR_W          = 32;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 20'd10;
   localparam logic [CFG_W-1:0] LONG_RESET      = 20'd500;
   localparam logic [CFG_W-1:0] VERY_LONG_RESET = 20'd2500;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERY_LONG = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      EV_SHORT     = 2'd0,
      EV_LONG      = 2'd1,
      EV_VERY_LONG = 2'd2
   } event_kind_type;

endpackage

// File: hw/rtl/bdpc_channels.sv
// ----------------------------------------------------------------------------
// bdpc channels
// Valid/ready channels for tick beats in and status beats out.
// ----------------------------------------------------------------------------
interface bdpc_req_if;
   logic valid;
   logic ready;
   logic raw_level;

   modport source (output valid, output raw_level, input ready);
   modport sink   (input valid, input raw_level, output ready);
endinterface

interface bdpc_rsp_if
   import bdpc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               event_valid;
   logic [KIND_W-1:0]  event_kind;
   logic               button_down;
   logic [KIND_W-1:0]  recent_kind;
   logic [TSR_W-1:0]   ticks_since_release;

   modport source (output valid, output event_valid, output event_kind,
                   output button_down, output recent_kind,
                   output ticks_since_release, input ready);
   modport sink   (input valid, input event_valid, input event_kind,
                   input button_down, input recent_kind,
                   input ticks_since_release, output ready);
endinterface

// File: hw/rtl/button_debounce_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Path: an accepted tick beat goes through the input register, one pass of
// compares and subtractions, and the result register to its status beat.
// Throughput: one tick per cycle while the status side is not stalled.
// Reset (synchronous): released level, idle countdown, times zero, last event
// short, thresholds back to 10 / 500 / 2500 ticks.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit
   import bdpc_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   bdpc_req_if.sink             req_chan,
   bdpc_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

   // configuration
   logic [CFG_W-1:0] dbt_ff, long_ff, vlong_ff;

   // input stage
   logic s1_valid_ff, s1_raw_ff;

   // block state
   logic                  prev_raw_ff, prev_raw_in;
   logic [CFG_W-1:0]      rem_ff, rem_in;
   logic                  stable_ff, stable_in;
   logic [TIME_WIDTH-1:0] tick_ff, tick_in;
   logic [TIME_WIDTH-1:0] press_ff, press_in;
   logic [TIME_WIDTH-1:0] release_ff, release_in;
   event_kind_type        kept_ff, kept_in;

   // result register
   logic                  out_valid_ff;
   logic                  ev_valid_ff;
   logic [KIND_W-1:0]     ev_kind_ff;
   logic                  down_ff;
   logic [KIND_W-1:0]     last_ff;
   logic [TSR_W-1:0]      tsr_ff;

   logic                  advance, process, sample, ev_valid;
   event_kind_type        ev_kind, held_kind;
   logic [TIME_WIDTH-1:0] held, since;
   logic [CMP_W-1:0]      held_c;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign process        = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbt_ff   <= DEBOUNCE_RESET;
         long_ff  <= LONG_RESET;
         vlong_ff <= VERY_LONG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE:  dbt_ff   <= csr_wdata;
            CSR_LONG:      long_ff  <= csr_wdata;
            CSR_VERY_LONG: vlong_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_raw_ff <= req_chan.raw_level;
      end
   end

   assign held   = tick_ff - press_ff;
   assign held_c = CMP_W'(held);

   always_comb begin
      if (held_c < CMP_W'(long_ff)) begin
         held_kind = EV_SHORT;
      end else if (held_c < CMP_W'(vlong_ff)) begin
         held_kind = EV_LONG;
      end else begin
         held_kind = EV_VERY_LONG;
      end
   end

   always_comb begin
      prev_raw_in = prev_raw_ff;
      rem_in      = rem_ff;
      stable_in   = stable_ff;
      tick_in     = tick_ff;
      press_in    = press_ff;
      release_in  = release_ff;
      kept_in     = kept_ff;
      sample      = 1'b0;
      ev_valid    = 1'b0;
      ev_kind     = EV_SHORT;
      if (process) begin
         if (s1_raw_ff != prev_raw_ff) begin
            // any edge restarts the countdown; zero acts as one
            prev_raw_in = s1_raw_ff;
            rem_in      = (dbt_ff == '0) ? CFG_W'(1) : dbt_ff;
         end else if (rem_ff != '0) begin
            rem_in = rem_ff - CFG_W'(1);
            sample = (rem_ff == CFG_W'(1));
         end
         if (sample && (s1_raw_ff != stable_ff)) begin
            stable_in = s1_raw_ff;
            if (!s1_raw_ff) begin
               press_in = tick_ff;
            end else begin
               release_in = tick_ff;
               kept_in    = held_kind;
               ev_valid   = 1'b1;
               ev_kind    = held_kind;
            end
         end
         tick_in = tick_ff + TIME_WIDTH'(1);
      end
   end

   assign since = tick_ff - release_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= 1'b1;
         rem_ff      <= '0;
         stable_ff   <= 1'b1;
         tick_ff     <= '0;
         press_ff    <= '0;
         release_ff  <= '0;
         kept_ff     <= EV_SHORT;
      end else begin
         prev_raw_ff <= prev_raw_in;
         rem_ff      <= rem_in;
         stable_ff   <= stable_in;
         tick_ff     <= tick_in;
         press_ff    <= press_in;
         release_ff  <= release_in;
         kept_ff     <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (process) begin
         ev_valid_ff <= ev_valid;
         ev_kind_ff  <= ev_kind;
         down_ff     <= !stable_in;
         last_ff     <= kept_in;
         tsr_ff      <= TSR_W'(since);
      end
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.event_valid         = ev_valid_ff;
   assign rsp_chan.event_kind          = ev_kind_ff;
   assign rsp_chan.button_down         = down_ff;
   assign rsp_chan.recent_kind         = last_ff;
   assign rsp_chan.ticks_since_release = tsr_ff;

endmodule

// File: hw/rtl/bdpc_checker.sv
// ----------------------------------------------------------------------------
// bdpc_checker
// Port-level checks of the button debounce / press classifier, bound to the unit.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_unit_assert.svh"

module bdpc_checker
   import bdpc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_event_valid,
   input logic [KIND_W-1:0] rsp_event_kind,
   input logic              rsp_button_down,
   input logic [KIND_W-1:0] rsp_recent_kind,
   input logic [TSR_W-1:0]  rsp_tsr
);

   // a release beat: button up, zero elapsed, class kept as last event
   `BDPC_CHECK(a_release_beat, rsp_valid && rsp_event_valid |-> !rsp_button_down && rsp_tsr == '0 && rsp_event_kind == rsp_recent_kind, "release beat inconsistent")

   `BDPC_CHECK(a_no_event_kind, rsp_valid && !rsp_event_valid |-> rsp_event_kind == EV_SHORT, "event kind set without event")

   `BDPC_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tsr) && $stable(rsp_recent_kind) && $stable(rsp_button_down) && $stable(rsp_event_valid), "stalled beat changed")

   // empty result register never blocks the input side
   `BDPC_CHECK(a_ready_when_empty, !rsp_valid |-> req_ready, "input stalled with empty output")

   `BDPC_CHECK_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_event_valid (rsp_chan.event_valid),
   .rsp_event_kind  (rsp_chan.event_kind),
   .rsp_button_down (rsp_chan.button_down),
   .rsp_recent_kind (rsp_chan.recent_kind),
   .rsp_tsr         (rsp_chan.ticks_since_release)
);
